// ===== sv/pidc_pkg.sv =====
// Shared types and constants for the discrete PID step core.
// Used by the controller, the datapath, the multiplier and the top level; no dependencies.
package pidc_pkg;

  // Width of the operand magnitudes fed to the shared multiplier.
  localparam int MagW  = 64;
  // Width of one saturated gain or integral term (magnitude at most 2^60, plus sign).
  localparam int TermW = 62;
  // Width of the running sum of up to three terms.
  localparam int SumW  = 63;
  // Width of a gain register.
  localparam int GainW = 32;
  // Width of the register index on the configuration port.
  localparam int CfgIdxW = 2;

  // Magnitude limit of every product and quotient term.
  localparam logic [MagW-1:0] TermLimit = 64'd1 << 60;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPropGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIntegGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDerivGain = 2'd2;

  // Operation codes carried in the input beat's user field.
  localparam logic OpCompute = 1'b0;
  localparam logic OpClear   = 1'b1;

  // Operand pair that the shared multiplier works on.
  typedef enum logic [1:0] {
    MulErrDt = 2'd0,
    MulProp  = 2'd1,
    MulInteg = 2'd2,
    MulDeriv = 2'd3
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     clear_state;
    logic     calc_err;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    logic     upd_integ;
    logic     sum_init;
    logic     sum_add;
    logic     load_out;
  } pidc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic deriv_rdy;
    logic out_free;
  } pidc_stat_t;

  // Magnitude of a signed 64-bit value, returned unsigned.
  function automatic logic [MagW-1:0] mag64(input logic [MagW-1:0] v);
    logic [MagW-1:0] u;
    u = v;
    return u[MagW-1] ? (~u + MagW'(1)) : u;
  endfunction

endpackage

// ===== sv/pidc_mul.sv =====
// Shared fixed-point multiplier: 64x64 magnitude product built from four
// 32x32 partial products, then shifted, saturated and signed. Uses pidc_pkg.
module pidc_mul #(
  parameter int FracBits = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [pidc_pkg::MagW-1:0]        a_i,
  input  logic [pidc_pkg::MagW-1:0]        b_i,
  input  logic                             neg_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic signed [pidc_pkg::TermW-1:0] term_o,
  output logic                             hit_o
);

  localparam int MagW  = pidc_pkg::MagW;
  localparam int TermW = pidc_pkg::TermW;
  localparam int HalfW = MagW / 2;
  localparam int ProdW = 2 * MagW;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [2:0]              ph_q, ph_d;
  logic [MagW-1:0]         a_q, b_q;
  logic                    neg_q;
  logic [MagW-1:0]         pp_q, pp_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic [ProdW-1:0]        addend;
  logic [HalfW-1:0]        mul_x, mul_y;
  logic [ProdW-1:0]        shifted;
  logic                    sat;
  logic [60:0]             mag61;
  logic [TermW-1:0]        mag_ext;
  logic signed [TermW-1:0] term_q, term_d;
  logic                    hit_q, hit_d;

  // Phase k of 0..3 picks the operand halves: low/low, low/high, high/low, high/high.
  assign mul_x = ph_q[1] ? a_q[MagW-1:HalfW] : a_q[HalfW-1:0];
  assign mul_y = ph_q[0] ? b_q[MagW-1:HalfW] : b_q[HalfW-1:0];
  assign pp_d  = mul_x * mul_y;

  // The partial product of the previous phase is added at its weight.
  always_comb begin
    unique case (ph_q)
      3'd1:       addend = ProdW'(pp_q);
      3'd2, 3'd3: addend = ProdW'(pp_q) << HalfW;
      3'd4:       addend = ProdW'(pp_q) << MagW;
      default:    addend = '0;
    endcase
  end
  assign prod_d = prod_q + addend;

  // Drop the fraction bits and clamp the magnitude to 2^60.
  assign shifted = prod_q >> FracBits;
  assign sat     = (|shifted[ProdW-1:61]) | (shifted[60] & (|shifted[59:0]));
  assign mag61   = sat ? pidc_pkg::TermLimit[60:0] : shifted[60:0];
  assign mag_ext = TermW'(mag61);
  assign term_d  = neg_q ? (~mag_ext + TermW'(1)) : mag_ext;
  assign hit_d   = sat;

  // Phase sequencing.
  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    done_d = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        ph_d   = 3'd0;
      end
    end else begin
      ph_d = ph_q + 3'd1;
      if (ph_q == 3'd5) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ph_q   <= ph_d;
    end
  end

  // Operand, product and result registers.
  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      neg_q  <= neg_i;
      prod_q <= '0;
    end else if (busy_q) begin
      pp_q   <= pp_d;
      prod_q <= prod_d;
      if (ph_q == 3'd5) begin
        term_q <= term_d;
        hit_q  <= hit_d;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign term_o = term_q;
  assign hit_o  = hit_q;

endmodule

// ===== sv/pidc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone unit; no package dependencies.
module pidc_div #(
  parameter int NumW = 49,
  parameter int DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] work_q, work_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_sh;
  logic [DenW:0]   rem_sub;
  logic            ge;

  // One step: shift in the next dividend bit, subtract when it fits.
  assign rem_sh  = {rem_q, work_q[NumW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign rem_d   = rem_sub[DenW-1:0];
  assign work_d  = {work_q[NumW-2:0], ge};

  // Step counter.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        cnt_d  = CntW'(NumW);
      end
    end else begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Dividend/quotient shift register and partial remainder.
  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      work_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = work_q;

endmodule

// ===== sv/pidc_datapath.sv =====
// Datapath of the PID step: input capture, gain registers, error, integral,
// derivative and output sum, plus the output beat register.
// Uses pidc_pkg, pidc_mul and pidc_div.
module pidc_datapath #(
  parameter int DataWidth = 32,
  parameter int FracBits  = 16,
  parameter int InDataW   = 96,
  parameter int OutDataW  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pidc_pkg::pidc_cmd_t             cmd_i,
  output pidc_pkg::pidc_stat_t            stat_o,
  input  logic [InDataW-1:0]              in_data_i,
  input  logic                            cfg_we_i,
  input  logic [pidc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pidc_pkg::GainW-1:0]      cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [OutDataW-1:0]             out_data_o,
  output logic [1:0]                      out_user_o
);

  localparam int DW    = DataWidth;
  localparam int MagW  = pidc_pkg::MagW;
  localparam int TermW = pidc_pkg::TermW;
  localparam int SumW  = pidc_pkg::SumW;
  localparam int GainW = pidc_pkg::GainW;
  localparam int AccW  = (DW + FracBits > 62) ? 62 : (DW + FracBits);
  localparam int NumW  = DW + 1 + FracBits;
  localparam int QW    = (NumW > MagW) ? NumW : MagW;

  localparam logic signed [DW:0]      ErrMax = (DW+1)'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [DW:0]      ErrMin = ~ErrMax;
  localparam logic signed [SumW-1:0]  AccMax = SumW'((64'sd1 <<< (AccW - 1)) - 64'sd1);
  localparam logic signed [SumW-1:0]  AccMin = ~AccMax;
  localparam logic signed [SumW-1:0]  DrvMax = SumW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [SumW-1:0]  DrvMin = ~DrvMax;
  localparam logic signed [TermW-1:0] DerivLim = TermW'(pidc_pkg::TermLimit);

  // Captured item, gains and controller state.
  logic signed [DW-1:0]    target_q, meas_q;
  logic [DW-1:0]           dt_q;
  logic signed [GainW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic signed [DW-1:0]    err_q, last_error_q;
  logic signed [AccW-1:0]  error_sum_q;
  logic signed [TermW-1:0] deriv_q;
  logic                    deriv_rdy_q;
  logic                    dneg_q;
  logic                    clip_q, zero_q;
  logic signed [SumW-1:0]  sum_q;
  logic                    out_valid_q;
  logic [DW-1:0]           drive_q;
  logic                    clipped_q, zero_out_q;

  logic signed [DW:0]      err_diff;
  logic [DW-1:0]           err_d;
  logic                    err_hit;
  logic signed [DW:0]      d_diff;
  logic [DW:0]             d_mag;
  logic [NumW-1:0]         div_num;
  logic                    div_start;
  logic                    div_busy, div_done;
  logic [NumW-1:0]         div_quo;
  logic [QW-1:0]           quo_ext;
  logic                    quo_sat;
  logic [TermW-1:0]        quo_mag;
  logic signed [TermW-1:0] deriv_d;

  logic [MagW-1:0]         mul_a, mul_b;
  logic                    mul_neg;
  logic                    mul_busy, mul_done;
  logic signed [TermW-1:0] mul_term;
  logic                    mul_hit;

  logic signed [SumW-1:0]  acc_sum;
  logic [AccW-1:0]         acc_sat;
  logic                    acc_hit;
  logic signed [SumW-1:0]  sum_next;
  logic [DW-1:0]           drive_d;
  logic                    drive_hit;

  // Error, saturated to the data width.
  assign err_diff = (DW+1)'(target_q) - (DW+1)'(meas_q);
  always_comb begin
    err_hit = 1'b0;
    if (err_diff > ErrMax) begin
      err_d   = ErrMax[DW-1:0];
      err_hit = 1'b1;
    end else if (err_diff < ErrMin) begin
      err_d   = ErrMin[DW-1:0];
      err_hit = 1'b1;
    end else begin
      err_d = err_diff[DW-1:0];
    end
  end

  // Derivative dividend: magnitude of the error change, scaled by the fraction bits.
  assign d_diff    = (DW+1)'(err_q) - (DW+1)'(last_error_q);
  assign d_mag     = d_diff[DW] ? (~d_diff + (DW+1)'(1)) : d_diff;
  assign div_num   = {d_mag, {FracBits{1'b0}}};
  assign div_start = cmd_i.div_start & ~zero_q;

  pidc_div #(
    .NumW (NumW),
    .DenW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dt_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Clamp the quotient magnitude to 2^60 and apply the sign of the change.
  assign quo_ext = QW'(div_quo);
  assign quo_sat = quo_ext > QW'(pidc_pkg::TermLimit);
  assign quo_mag = quo_sat ? TermW'(pidc_pkg::TermLimit) : quo_ext[TermW-1:0];
  assign deriv_d = dneg_q ? (~quo_mag + TermW'(1)) : quo_mag;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd_i.mul_sel)
      pidc_pkg::MulErrDt: begin
        mul_a   = pidc_pkg::mag64(MagW'(err_q));
        mul_b   = MagW'(dt_q);
        mul_neg = err_q[DW-1];
      end
      pidc_pkg::MulProp: begin
        mul_a   = pidc_pkg::mag64(MagW'(prop_gain_q));
        mul_b   = pidc_pkg::mag64(MagW'(err_q));
        mul_neg = prop_gain_q[GainW-1] ^ err_q[DW-1];
      end
      pidc_pkg::MulInteg: begin
        mul_a   = pidc_pkg::mag64(MagW'(integ_gain_q));
        mul_b   = pidc_pkg::mag64(MagW'(error_sum_q));
        mul_neg = integ_gain_q[GainW-1] ^ error_sum_q[AccW-1];
      end
      default: begin
        mul_a   = pidc_pkg::mag64(MagW'(deriv_gain_q));
        mul_b   = pidc_pkg::mag64(MagW'(deriv_q));
        mul_neg = deriv_gain_q[GainW-1] ^ deriv_q[TermW-1];
      end
    endcase
  end

  pidc_mul #(
    .FracBits (FracBits)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .neg_i   (mul_neg),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .term_o  (mul_term),
    .hit_o   (mul_hit)
  );

  // New integral, saturated to the accumulator width.
  assign acc_sum = SumW'(error_sum_q) + SumW'(mul_term);
  always_comb begin
    acc_hit = 1'b0;
    if (acc_sum > AccMax) begin
      acc_sat = AccMax[AccW-1:0];
      acc_hit = 1'b1;
    end else if (acc_sum < AccMin) begin
      acc_sat = AccMin[AccW-1:0];
      acc_hit = 1'b1;
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  // Output sum and its saturation to the data width.
  assign sum_next = sum_q + SumW'(mul_term);
  always_comb begin
    drive_hit = 1'b0;
    if (sum_q > DrvMax) begin
      drive_d   = DrvMax[DW-1:0];
      drive_hit = 1'b1;
    end else if (sum_q < DrvMin) begin
      drive_d   = DrvMin[DW-1:0];
      drive_hit = 1'b1;
    end else begin
      drive_d = sum_q[DW-1:0];
    end
  end

  // Gain registers, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pidc_pkg::CfgPropGain:  prop_gain_q  <= cfg_wdata_i;
        pidc_pkg::CfgIntegGain: integ_gain_q <= cfg_wdata_i;
        pidc_pkg::CfgDerivGain: deriv_gain_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Controller state that survives between items, and the per-item flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      error_sum_q  <= '0;
      deriv_q      <= '0;
      deriv_rdy_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_state) begin
        last_error_q <= '0;
        error_sum_q  <= '0;
      end else if (cmd_i.upd_integ) begin
        last_error_q <= err_q;
        error_sum_q  <= acc_sat;
      end
      if (cmd_i.calc_err) begin
        deriv_rdy_q <= (dt_q == '0);
        deriv_q     <= '0;
      end else if (div_done) begin
        deriv_rdy_q <= 1'b1;
        deriv_q     <= deriv_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, sum and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      target_q <= in_data_i[DW-1:0];
      meas_q   <= in_data_i[2*DW-1:DW];
      dt_q     <= in_data_i[3*DW-1:2*DW];
    end
    if (cmd_i.calc_err) begin
      err_q  <= err_d;
      clip_q <= err_hit;
      zero_q <= (dt_q == '0);
    end else if (cmd_i.upd_integ) begin
      clip_q <= clip_q | mul_hit | acc_hit;
    end
    if (div_start) begin
      dneg_q <= d_diff[DW];
    end
    if (cmd_i.sum_init) begin
      sum_q <= SumW'(mul_term);
    end else if (cmd_i.sum_add) begin
      sum_q <= sum_next;
    end
    if (cmd_i.load_out) begin
      drive_q    <= drive_d;
      clipped_q  <= clip_q | drive_hit;
      zero_out_q <= zero_q;
    end
  end

  assign stat_o.mul_done  = mul_done;
  assign stat_o.deriv_rdy = deriv_rdy_q;
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OutDataW'(drive_q);
  assign out_user_o  = {zero_out_q, clipped_q};

  // The multiplier and the divider are never restarted while busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The stored derivative stays within the term limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deriv_q <= DerivLim) && (deriv_q >= -DerivLim))
    else $error("derivative outside term limit");

  // A result is loaded only when the previous beat is gone or leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output beat overwritten");

endmodule

// ===== sv/pidc_ctrl.sv =====
// Controller state machine of the PID step: handles clear items and sequences error,
// integral, the three gain products and the output beat. Uses pidc_pkg.
module pidc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  input  pidc_pkg::pidc_stat_t stat_i,
  output pidc_pkg::pidc_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    StIdle   = 12'b0000_0000_0001,
    StErr    = 12'b0000_0000_0010,
    StInteg  = 12'b0000_0000_0100,
    StIntegW = 12'b0000_0000_1000,
    StProp   = 12'b0000_0001_0000,
    StPropW  = 12'b0000_0010_0000,
    StIGain  = 12'b0000_0100_0000,
    StIGainW = 12'b0000_1000_0000,
    StDWait  = 12'b0001_0000_0000,
    StDGain  = 12'b0010_0000_0000,
    StDGainW = 12'b0100_0000_0000,
    StResult = 12'b1000_0000_0000
  } pidc_state_e;

  pidc_state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = pidc_pkg::MulErrDt;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (in_op_i == pidc_pkg::OpClear) begin
            cmd_o.clear_state = 1'b1;
          end else begin
            state_d = StErr;
          end
        end
      end
      StErr: begin
        cmd_o.calc_err = 1'b1;
        state_d        = StInteg;
      end
      StInteg: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = pidc_pkg::MulErrDt;
        cmd_o.div_start = 1'b1;
        state_d         = StIntegW;
      end
      StIntegW: begin
        if (stat_i.mul_done) begin
          cmd_o.upd_integ = 1'b1;
          state_d         = StProp;
        end
      end
      StProp: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = pidc_pkg::MulProp;
        state_d         = StPropW;
      end
      StPropW: begin
        if (stat_i.mul_done) begin
          cmd_o.sum_init = 1'b1;
          state_d        = StIGain;
        end
      end
      StIGain: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = pidc_pkg::MulInteg;
        state_d         = StIGainW;
      end
      StIGainW: begin
        if (stat_i.mul_done) begin
          cmd_o.sum_add = 1'b1;
          state_d       = StDWait;
        end
      end
      StDWait: begin
        if (stat_i.deriv_rdy) begin
          state_d = StDGain;
        end
      end
      StDGain: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = pidc_pkg::MulDeriv;
        state_d         = StDGainW;
      end
      StDGainW: begin
        cmd_o.mul_sel = pidc_pkg::MulDeriv;
        if (stat_i.mul_done) begin
          cmd_o.sum_add = 1'b1;
          state_d       = StResult;
        end
      end
      StResult: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/pid_controller_step_core.sv =====
// Top level of the discrete PID step core: controller plus datapath.
// Uses pidc_pkg, pidc_ctrl and pidc_datapath.
//
// Each input beat is either a clear item (integral and previous error go to zero,
// no result) or a compute item that yields one output beat. With a nonzero
// time step the derivative comes from a bit-serial divider with DATA_WIDTH +
// FRAC_BITS + 1 steps that starts together with the error-times-time-step
// product, once the error is registered, and runs alongside the first three
// passes through the shared multiplier; the derivative gain product and the
// result load follow once it is done. The shared multiplier forms all four
// products (error times time step and the three gain terms). With a zero time
// step the divider is skipped. Items are handled one at a time; the next item
// is accepted as soon as the result sits in the output register, and a result
// still waiting there holds the following one back.
module pid_controller_step_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0 up: target, measurement, time_step; zero padding to bytes.
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Fields from bit 0 up: operation.
  input  logic                          s_axis_tuser,
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0 up: drive; zero padding to bytes.
  output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // Fields from bit 0 up: clipped, zero_step.
  output logic [1:0]                    m_axis_tuser,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [pidc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pidc_pkg::GainW-1:0]    cfg_wdata_i
);

  localparam int InDataW  = ((3 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OutDataW = ((DATA_WIDTH + 7) / 8) * 8;

  pidc_pkg::pidc_cmd_t  cmd;
  pidc_pkg::pidc_stat_t stat;

  // Sequencer.
  pidc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  pidc_datapath #(
    .DataWidth (DATA_WIDTH),
    .FracBits  (FRAC_BITS),
    .InDataW   (InDataW),
    .OutDataW  (OutDataW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule
